FILE: hdl/encoded_pointer_decoder_macros.svh
// assertion macros shared by the encoded pointer decoder
`ifndef ENCODED_POINTER_DECODER_MACROS_SVH
`define ENCODED_POINTER_DECODER_MACROS_SVH

// same-cycle implication, held off during reset
`define EPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epd check failed");

// next-cycle implication, held off during reset
`define EPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epd check failed");

`endif

FILE: hdl/epd_pkg.sv
// types, codes and helper functions of the encoded pointer decoder
`timescale 1ns / 1ps
package epd_pkg;

    // input item actions
    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_END   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [1:0] CFG_WORD_IS_64    = 2'd0;
    localparam logic [1:0] CFG_LITTLE_ENDIAN = 2'd1;
    localparam logic [1:0] CFG_SECTION_BASE  = 2'd2;

    // format codes (low nibble of the encoding)
    localparam logic [3:0] FMT_ULEB128 = 4'h1;
    localparam logic [3:0] FMT_UDATA2  = 4'h2;
    localparam logic [3:0] FMT_UDATA4  = 4'h3;
    localparam logic [3:0] FMT_UDATA8  = 4'h4;
    localparam logic [3:0] FMT_SLEB128 = 4'h9;
    localparam logic [3:0] FMT_SDATA2  = 4'hA;
    localparam logic [3:0] FMT_SDATA4  = 4'hB;
    localparam logic [3:0] FMT_SDATA8  = 4'hC;

    // application code (high nibble of the encoding)
    localparam logic [3:0] APP_PCREL = 4'h1;

    localparam int CNT_W = 4;

    typedef struct packed {
        t_action     action;
        logic [7:0]  encoding;
        logic [31:0] field_offset;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [31:0] next_offset;
        logic        status;
    } t_out_item;

    // configuration seen by the decode stage
    typedef struct packed {
        logic        word_is_64;
        logic        little_endian;
        logic [63:0] base_next;
    } t_cfg;

    // byte width of a fixed format, zero for the leb formats, the word width for any other code
    function automatic logic [CNT_W-1:0] fixed_width(input logic [3:0] fmt,
                                                     input logic word_is_64);
        logic [CNT_W-1:0] w;
        begin
            case (fmt)
                FMT_ULEB128, FMT_SLEB128: w = 4'd0;
                FMT_UDATA2, FMT_SDATA2:   w = 4'd2;
                FMT_UDATA4, FMT_SDATA4:   w = 4'd4;
                FMT_UDATA8, FMT_SDATA8:   w = 4'd8;
                default:                  w = word_is_64 ? 4'd8 : 4'd4;
            endcase
            return w;
        end
    endfunction

    // sign extension of the short signed fixed formats
    function automatic logic [63:0] sign_fixed(input logic [3:0] fmt,
                                               input logic [63:0] v);
        logic [63:0] r;
        begin
            r = v;
            if (fmt == FMT_SDATA2) begin
                r = {{48{v[15]}}, v[15:0]};
            end else if (fmt == FMT_SDATA4) begin
                r = {{32{v[31]}}, v[31:0]};
            end
            return r;
        end
    endfunction

    // sleb sign extension above the filled bits
    function automatic logic [63:0] sleb_extend(input logic [63:0] v,
                                                input logic [CNT_W-1:0] count,
                                                input logic sign);
        logic [6:0]  shift;
        logic [63:0] r;
        begin
            shift = 7'(count) * 7'd7;
            r = v;
            if (count != '0 && shift < 7'd64 && sign) begin
                r = v | ({64{1'b1}} << shift[5:0]);
            end
            return r;
        end
    endfunction

endpackage

FILE: hdl/epd_in_stage.sv
// input register of the encoded pointer decoder
`timescale 1ns / 1ps
module epd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  epd_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output epd_pkg::t_in_item o_item
);
    import epd_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_take;

    // hold off new transfers only while the held item cannot move on
    assign o_in_stall = r_valid && !i_advance;
    assign w_take     = i_in_valid && !o_in_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

FILE: hdl/epd_decode.sv
// field state and combinational decode of one byte, begin or end item
`timescale 1ns / 1ps
module epd_decode #(
    parameter int MAX_LEB_BYTES = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epd_pkg::t_cfg      i_cfg,
    input  epd_pkg::t_in_item  i_item,
    input  logic               i_go,
    output logic               o_emit,
    output epd_pkg::t_out_item o_result
);
    import epd_pkg::*;

    logic [63:0]      r_acc,    n_acc;
    logic [CNT_W-1:0] r_taken,  n_taken;
    logic [7:0]       r_enc,    n_enc;
    logic [31:0]      r_start,  n_start;
    logic             r_active, n_active;
    logic             r_sign,   n_sign;
    logic [63:0]      r_adj;

    logic [3:0]       w_fmt;
    logic [CNT_W-1:0] w_width;
    logic [CNT_W:0]   w_k1;
    logic [6:0]       w_leb_shift;
    logic [63:0]      w_leb_or;
    logic [63:0]      w_raw;
    logic [CNT_W-1:0] w_consumed;
    logic             w_status;
    logic             w_emit;
    logic [7:0]       w_b;

    assign w_fmt       = r_enc[3:0];
    assign w_b         = i_item.data_byte;
    assign w_width     = fixed_width(w_fmt, i_cfg.word_is_64);
    assign w_k1        = {1'b0, r_taken} + (CNT_W+1)'(1);
    assign w_leb_shift = 7'(r_taken) * 7'd7;
    assign w_leb_or    = (w_leb_shift < 7'd64) ?
                         ({57'd0, w_b[6:0]} << w_leb_shift[5:0]) : 64'd0;

    // next state and raw result
    always_comb begin
        n_acc      = r_acc;
        n_taken    = r_taken;
        n_enc      = r_enc;
        n_start    = r_start;
        n_active   = r_active;
        n_sign     = r_sign;
        w_raw      = 64'd0;
        w_consumed = '0;
        w_status   = 1'b0;
        w_emit     = 1'b0;
        case (i_item.action)
            ACT_BEGIN: begin
                n_enc    = i_item.encoding;
                n_start  = i_item.field_offset;
                n_acc    = 64'd0;
                n_taken  = '0;
                n_sign   = 1'b0;
                n_active = 1'b1;
            end
            ACT_DATA: begin
                if (r_active) begin
                    n_taken = w_k1[CNT_W-1:0];
                    if (w_width == '0) begin
                        // leb: seven bits per byte, a clear stop bit or MAX_LEB_BYTES bytes end the field
                        n_acc  = r_acc | w_leb_or;
                        n_sign = w_b[6];
                        if (!w_b[7] || w_k1 >= (CNT_W+1)'(MAX_LEB_BYTES)) begin
                            w_emit     = 1'b1;
                            w_consumed = w_k1[CNT_W-1:0];
                            w_raw      = (w_fmt == FMT_SLEB128) ?
                                         sleb_extend(n_acc, w_k1[CNT_W-1:0], w_b[6]) :
                                         n_acc;
                        end
                    end else begin
                        // fixed width: gather bytes in the configured order
                        if (i_cfg.little_endian) begin
                            n_acc = r_acc | ({56'd0, w_b} << {r_taken[2:0], 3'b000});
                        end else begin
                            n_acc = {r_acc[55:0], w_b};
                        end
                        if (w_k1 >= {1'b0, w_width}) begin
                            w_emit     = 1'b1;
                            w_consumed = w_width;
                            w_raw      = sign_fixed(w_fmt, n_acc);
                        end
                    end
                end
            end
            ACT_END: begin
                if (r_active) begin
                    w_emit   = 1'b1;
                    w_status = 1'b1;
                    if (w_fmt == FMT_ULEB128) begin
                        w_raw      = r_acc;
                        w_consumed = r_taken;
                    end else if (w_fmt == FMT_SLEB128) begin
                        w_raw      = sleb_extend(r_acc, r_taken, r_sign);
                        w_consumed = r_taken;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            n_active = 1'b0;
        end
    end

    // result with the pc-relative adjustment
    assign o_emit               = w_emit;
    assign o_result.value       = w_raw + ((r_enc[7:4] == APP_PCREL) ? r_adj : 64'd0);
    assign o_result.next_offset = r_start + 32'(w_consumed);
    assign o_result.status      = w_status;

    // field state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 64'd0;
            r_taken  <= '0;
            r_enc    <= 8'd0;
            r_start  <= 32'd0;
            r_active <= 1'b0;
            r_sign   <= 1'b0;
        end else if (i_go) begin
            r_acc    <= n_acc;
            r_taken  <= n_taken;
            r_enc    <= n_enc;
            r_start  <= n_start;
            r_active <= n_active;
            r_sign   <= n_sign;
        end
    end

    // section base plus field start, kept ready ahead of the field's bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj <= 64'd0;
        end else begin
            r_adj <= i_cfg.base_next + {32'd0, (i_go ? n_start : r_start)};
        end
    end
endmodule

FILE: hdl/epd_out_stage.sv
// result register of the encoded pointer decoder
`timescale 1ns / 1ps
module epd_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  epd_pkg::t_out_item i_result,
    output logic               o_free,
    output logic               o_out_valid,
    output epd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import epd_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // room for a new result when empty or draining this cycle
    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;
endmodule

FILE: hdl/encoded_pointer_decoder.sv
// Encoded pointer decoder: takes one item per clock (begin, data byte or end) and
// returns the decoded 64-bit pointer when a ULEB128, SLEB128 or fixed-width field
// completes, with status set when an end item cuts it short. An accepted item is
// held in the input register, decoded in one pass against the field state, and
// its result lands in the output register. The sustained rate is one item per
// cycle while the input is not stalled; the input stalls only while a result
// must be written and the output register is full and stalled.
// Configuration writes take effect on the next item decoded.
`timescale 1ns / 1ps
module encoded_pointer_decoder #(
    parameter int MAX_LEB_BYTES = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  epd_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output epd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    import epd_pkg::*;

    `include "encoded_pointer_decoder_macros.svh"

    logic        r_word_is_64;
    logic        r_little_endian;
    logic [63:0] r_section_base;

    t_cfg        w_cfg;
    logic        w_in_valid;
    t_in_item    w_item;
    logic        w_emit;
    t_out_item   w_result;
    logic        w_out_free;
    logic        w_go;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_is_64    <= 1'b1;
            r_little_endian <= 1'b1;
            r_section_base  <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WORD_IS_64:    r_word_is_64    <= i_cfg_data[0];
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data[0];
                CFG_SECTION_BASE:  r_section_base  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.word_is_64    = r_word_is_64;
    assign w_cfg.little_endian = r_little_endian;
    assign w_cfg.base_next     = (i_cfg_we && i_cfg_idx == CFG_SECTION_BASE) ?
                                 i_cfg_data : r_section_base;

    // the held item moves on unless it has a result with nowhere to go
    assign w_go = w_in_valid && (!w_emit || w_out_free);

    epd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_advance  (w_go),
        .o_valid    (w_in_valid),
        .o_item     (w_item)
    );

    epd_decode #(
        .MAX_LEB_BYTES (MAX_LEB_BYTES)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (w_item),
        .i_go     (w_go),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    epd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_go && w_emit),
        .i_result    (w_result),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // input backs up only behind a full, stalled result register
    `EPD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // a result needs a held item the cycle before
    `EPD_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !o_out_valid && !w_in_valid, !o_out_valid)
    // a held item that yields a result while the output is free always moves
    `EPD_ASSERT_NOW(a_no_deadlock, i_clk, i_rst_n, w_in_valid && !o_out_valid, w_go)
endmodule
